// ===== rtl/tccs_pkg.sv =====
package tccs_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int RW  = $clog2(ROWS);
  localparam int XW  = $clog2(COLUMNS);
  localparam int CW  = $clog2(COLUMNS + 1);
  localparam int AW  = $clog2(CELLS);
  localparam int MW  = 8 + CW;
  localparam int PAW = 3;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;
  localparam logic [3:0] RESET_FG     = 4'd7;
  localparam logic [3:0] RESET_BG     = 4'd0;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef logic [RW-1:0] row_t;
  typedef logic [XW-1:0] col_t;
  typedef logic [CW-1:0] fill_t;
  typedef logic [AW-1:0] addr_t;

  localparam row_t LAST_ROW = RW'(ROWS - 1);

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // per physical row: blank attribute and count of written cells from column 0
  typedef struct packed {
    logic [7:0] attr;
    fill_t      fill;
  } row_meta_t;

  function automatic row_t phys_row(row_t lrow, row_t top);
    logic [RW:0] s;
    s = {1'b0, lrow} + {1'b0, top};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  function automatic addr_t cell_addr(row_t prow, col_t col);
    return AW'(prow) * AW'(COLUMNS) + AW'(col);
  endfunction

endpackage

// ===== rtl/tccs_ram.sv =====
module tccs_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tccs_cfg.sv =====
module tccs_cfg
  import tccs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output logic [7:0]     attr
);

  logic [3:0] fg_r, fg_nxt;
  logic [3:0] bg_r, bg_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_FG: fg_nxt = pwdata[3:0];
        REG_BG: bg_nxt = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= RESET_FG;
      bg_r <= RESET_BG;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FG:  prdata = {28'd0, fg_r};
      REG_BG:  prdata = {28'd0, bg_r};
      default: prdata = 32'd0;
    endcase
  end

  assign attr = {bg_r, fg_r};

endmodule

// ===== rtl/tccs_core.sv =====
module tccs_core
  import tccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] attr,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_char_code,
  input  logic [4:0] in_read_row,
  input  logic [6:0] in_read_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_attr,
  output logic [4:0] out_cursor_y,
  output logic [6:0] out_cursor_x,
  output logic       out_scrolled
);

  state_t      st_r, st_nxt;
  row_t        cur_row_r, cur_row_nxt;
  col_t        cur_col_r, cur_col_nxt;
  row_t        top_r, top_nxt;
  logic [7:0]  cur_attr_r, cur_attr_nxt;
  logic [ROWS-1:0] row_vld_r, row_vld_nxt;

  cmd_t        cmd_r;
  logic [7:0]  char_r;
  row_t        rd_lrow_r;
  row_t        rd_prow_r;
  col_t        rd_col_r;
  logic        rd_inr_r;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic [7:0]  out_attr_r, out_attr_nxt;
  logic [4:0]  out_y_r, out_y_nxt;
  logic [6:0]  out_x_r, out_x_nxt;
  logic        out_scr_r, out_scr_nxt;

  logic        accept, done;
  logic        in_is_read;
  row_t        in_lrow, in_prow, cur_phys;
  col_t        in_col;
  logic        in_inr;

  logic        cell_we, cell_re;
  addr_t       cell_waddr, cell_raddr;
  logic [15:0] cell_wdata, cell_rdata;

  logic        meta_we, meta_re;
  row_t        meta_waddr, meta_raddr;
  row_meta_t   meta_wdata, meta_rdata;

  logic        is_put, is_nl, leave, last, scroll, on_cur;
  fill_t       col_inc, fill_sel;
  logic [7:0]  attr_sel;
  logic [15:0] cell_sel;

  // front: accept and issue memory accesses
  assign in_is_read = (in_cmd == CMD_READ);
  assign in_lrow    = RW'(in_read_row);
  assign in_col     = XW'(in_read_col);
  assign in_inr     = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS);
  assign in_prow    = phys_row(in_lrow, top_r);
  assign cur_phys   = phys_row(cur_row_r, top_r);

  assign accept     = in_valid && in_ready;

  assign cell_we    = accept && !in_is_read && (in_char_code != NEWLINE_CODE);
  assign cell_waddr = cell_addr(cur_phys, cur_col_r);
  assign cell_wdata = {attr, in_char_code};
  assign cell_re    = accept && in_is_read;
  assign cell_raddr = cell_addr(in_prow, in_col);

  assign meta_re    = cell_re;
  assign meta_raddr = in_prow;

  tccs_ram #(.DW(16), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  tccs_ram #(.DW(MW), .DEPTH(ROWS)) u_rows (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= cmd_t'(in_cmd);
      char_r    <= in_char_code;
      rd_lrow_r <= in_lrow;
      rd_prow_r <= in_prow;
      rd_col_r  <= in_col;
      rd_inr_r  <= in_inr;
    end
  end

  // execute: cursor update, row bookkeeping and read result
  assign is_put  = (cmd_r == CMD_PUT);
  assign is_nl   = (char_r == NEWLINE_CODE);
  assign col_inc = CW'(cur_col_r) + (is_nl ? CW'(0) : CW'(1));
  assign leave   = is_put && (is_nl || (col_inc == CW'(COLUMNS)));
  assign last    = (cur_row_r == LAST_ROW);
  assign scroll  = leave && last;
  assign on_cur  = (rd_lrow_r == cur_row_r);

  always_comb begin
    if (on_cur) begin
      fill_sel = CW'(cur_col_r);
      attr_sel = cur_attr_r;
    end else if (row_vld_r[rd_prow_r]) begin
      fill_sel = meta_rdata.fill;
      attr_sel = meta_rdata.attr;
    end else begin
      fill_sel = '0;
      attr_sel = RESET_ATTR;
    end
    cell_sel = (CW'(rd_col_r) < fill_sel) ? cell_rdata : {attr_sel, BLANK_CODE};
  end

  always_comb begin
    st_nxt        = st_r;
    in_ready      = 1'b0;
    done          = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          st_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        done = !out_valid_r || out_ready;
        if (done) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    top_nxt      = top_r;
    cur_attr_nxt = cur_attr_r;
    row_vld_nxt  = row_vld_r;
    meta_we      = 1'b0;
    meta_waddr   = cur_phys;
    meta_wdata   = '{attr: cur_attr_r, fill: col_inc};
    if (done && is_put) begin
      if (leave) begin
        meta_we               = 1'b1;
        row_vld_nxt[cur_phys] = 1'b1;
        cur_col_nxt           = '0;
        if (last) begin
          top_nxt      = (top_r == LAST_ROW) ? '0 : top_r + row_t'(1);
          cur_attr_nxt = attr;
        end else begin
          cur_row_nxt  = cur_row_r + row_t'(1);
          cur_attr_nxt = RESET_ATTR;
        end
      end else begin
        cur_col_nxt = col_inc[XW-1:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    out_y_nxt     = out_y_r;
    out_x_nxt     = out_x_r;
    out_scr_nxt   = out_scr_r;
    if (done) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = (!is_put && rd_inr_r) ? cell_sel[7:0]  : 8'd0;
      out_attr_nxt  = (!is_put && rd_inr_r) ? cell_sel[15:8] : 8'd0;
      out_y_nxt     = 5'(cur_row_nxt);
      out_x_nxt     = 7'(cur_col_nxt);
      out_scr_nxt   = scroll;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      cur_attr_r  <= RESET_ATTR;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      cur_attr_r  <= cur_attr_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_y_r    <= out_y_nxt;
    out_x_r    <= out_x_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cell_char = out_char_r;
  assign out_cell_attr = out_attr_r;
  assign out_cursor_y  = out_y_r;
  assign out_cursor_x  = out_x_r;
  assign out_scrolled  = out_scr_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_row_r) < ROWS) && (32'(cur_col_r) < COLUMNS) && (32'(top_r) < ROWS))
    else $error("cursor or top row out of range");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scr_r |-> (out_x_r == 7'd0) && (out_y_r == 5'(ROWS - 1)))
    else $error("scroll result not at start of last row");

  a_row_left: assert property (@(posedge clk) disable iff (!rst_n)
    meta_we |=> (cur_phys != $past(meta_waddr)))
    else $error("cursor still on the row just closed");

  a_cell_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    meta_we |-> !cell_we && (st_r == ST_EXEC))
    else $error("row close overlaps a cell write");

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// Text console engine: a ROWS x COLUMNS store of 16-bit cells plus a cursor.
// Input channel (in_*): cmd 0 puts char_code at the cursor (10 is newline),
// cmd 1 reads the cell at read_row/read_col. Every transfer in gives exactly
// one transfer out (out_*): the cell read (zero for puts or off-screen reads),
// the cursor after the item and whether it scrolled the screen.
// in_ready is high only in the idle state, so a new item is taken only once
// the last one has been executed. The cell and row-info RAM reads return in the
// cycle after a transfer in, and the result is then loaded into the output
// register as soon as that register is free, which raises out_valid.
// Scrolling moves a top-row pointer and closes rows through the row-info RAM,
// so a scroll takes no longer than any other item.
// If the receiver stalls, the result is held and one more item may be taken;
// that item waits in its execute cycle until the output register frees up.
// Reset (rst_n, synchronous) homes the cursor and leaves the screen reading
// as blanks with attribute 0x07 at once; no clearing pass is needed.
// fg_color (0x0) and bg_color (0x4) are written over the APB port and set the
// attribute of cells written afterwards and of rows blanked by a later scroll.
module text_console_cursor_scroll
  import tccs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cmd,
  input  logic [7:0]     in_char_code,
  input  logic [4:0]     in_read_row,
  input  logic [6:0]     in_read_col,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_cell_char,
  output logic [7:0]     out_cell_attr,
  output logic [4:0]     out_cursor_y,
  output logic [6:0]     out_cursor_x,
  output logic           out_scrolled
);

  logic [7:0] attr;

  tccs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  tccs_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .attr          (attr),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .out_cursor_y  (out_cursor_y),
    .out_cursor_x  (out_cursor_x),
    .out_scrolled  (out_scrolled)
  );

endmodule
